// ===== hw/rtl/dgsp_pkg.sv =====
package dgsp_pkg;

   localparam int DIST_BITS = 24;
   localparam logic [DIST_BITS-1:0] DIST_INF = 24'hFFFFFF;
   localparam int TOTAL_BITS = 36;
   localparam int COUNT_BITS = 11;
   localparam int VCNT_BITS = 7;
   localparam logic [VCNT_BITS-1:0] VCNT_RESET = 7'd50;

   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_UPDATE = 3'd1;
   localparam logic [2:0] REQ_REMOVE = 3'd2;
   localparam logic [2:0] REQ_PATH   = 3'd3;
   localparam logic [2:0] REQ_ALL    = 3'd4;

   localparam logic [0:0] CSR_VERTEX_COUNT = 1'd0;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;    // clear edge present bits for one row
      logic edge_read;     // read ab present bit
      logic edge_write_ab; // write ab entry
      logic edge_write_ba; // write ba entry
      logic init_search;   // start new search
      logic scan_step;     // one vertex of the minimum scan
      logic select_done;   // latch best vertex
      logic relax_step;    // one vertex of relaxation
      logic relax_rd;      // issue row read
      logic pair_init;     // reset pair indexes and sums
      logic pair_next;     // accumulate and advance
      logic load_result;   // load output register
   } dgsp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic present_ab;
      logic scan_last;
      logic relax_last;
      logic pass_last;
      logic best_inf;
      logic pair_last;
      logic pair_none;
   } dgsp_sts_type;

endpackage

// ===== hw/rtl/dgsp_datapath.sv =====
module dgsp_datapath
   import dgsp_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int COST_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dgsp_cmd_type           cmd,
   output dgsp_sts_type           sts,
   input  logic [2:0]             req_kind,
   input  logic [5:0]             vtx_a,
   input  logic [5:0]             vtx_b,
   input  logic [15:0]            cost,
   input  logic [VCNT_BITS-1:0]   vcount,
   input  logic                   is_all,
   output logic [DIST_BITS-1:0]   res_cost,
   output logic                   res_found,
   output logic [TOTAL_BITS-1:0]  res_total,
   output logic [COUNT_BITS-1:0]  res_count,
   output logic                   query_ok
);

   localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NB = VB + 1;
   localparam int EB = 2 * VB;
   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;

   logic [MAX_VERTICES-1:0] present_mem [MAX_VERTICES];
   logic [COST_BITS-1:0]    weight_mem  [DEPTH];
   logic [DIST_BITS-1:0]    dist_mem    [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;

   logic [NB-1:0] n_eff;
   logic [VB-1:0] idx_ff, idx_in;
   logic [VB-1:0] best_idx_ff, best_idx_in;
   logic [DIST_BITS-1:0] best_ff, best_in;
   logic [DIST_BITS-1:0] du_ff, du_in;
   logic [VB-1:0] u_ff, u_in;
   logic [NB-1:0] pass_ff, pass_in;
   logic [VB-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic present_ab_ff;
   logic [MAX_VERTICES-1:0] row_ff;
   logic [COST_BITS-1:0] wrd_ff;
   logic [DIST_BITS-1:0] drd_ff;
   logic [VB-1:0] ridx_ff;
   logic rvalid_ff;
   logic [VB-1:0] ea, eb;
   logic ep_ok;

   assign n_eff = ({1'b0, vcount} > NB'(MAX_VERTICES)) ? NB'(MAX_VERTICES)
                  : NB'(vcount);
   assign ep_ok = (32'(vtx_a) < MAX_VERTICES) && (32'(vtx_b) < MAX_VERTICES);
   assign ea = VB'(vtx_a);
   assign eb = VB'(vtx_b);
   assign query_ok = (vtx_a != vtx_b) && ({1'b0, vtx_a} < 7'(n_eff))
                     && ({1'b0, vtx_b} < 7'(n_eff)) && ep_ok;

   // edge stores
   always_ff @(posedge clock) begin
      if (cmd.clear_step) present_mem[idx_ff] <= '0;
      if (cmd.edge_write_ab) begin
         present_mem[ea][eb] <= (req_kind != REQ_REMOVE);
         if (req_kind != REQ_REMOVE) weight_mem[{ea, eb}] <= COST_BITS'(cost);
      end
      if (cmd.edge_write_ba) begin
         present_mem[eb][ea] <= (req_kind != REQ_REMOVE);
         if (req_kind != REQ_REMOVE) weight_mem[{eb, ea}] <= COST_BITS'(cost);
      end
      if (cmd.edge_read) present_ab_ff <= present_mem[ea][eb];
   end

   // row read for scan and relaxation, one vertex per cycle
   always_ff @(posedge clock) begin
      row_ff <= present_mem[u_ff];
      wrd_ff <= weight_mem[{u_ff, idx_ff}];
      drd_ff <= dist_mem[idx_ff];
      ridx_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else rvalid_ff <= cmd.scan_step || cmd.relax_step;
   end

   logic [DIST_BITS:0] sum;
   logic [DIST_BITS-1:0] relaxed;
   assign sum = {1'b0, du_ff} + (DIST_BITS+1)'(wrd_ff);
   assign relaxed = (sum >= {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_BITS-1:0];

   // distance memory writes: init one per cycle via scan of init, relax writes
   logic dist_we;
   logic [VB-1:0] dist_wa;
   logic [DIST_BITS-1:0] dist_wd;
   logic relax_ph_ff;
   logic init_ph_ff;
   logic [DIST_BITS-1:0] dst_dist_ff;
   logic [DIST_BITS-1:0] dst_cur;

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
   end

   // copy of the target distance, follows every write to that entry
   always_ff @(posedge clock) begin
      if (dist_we && dist_wa == dst_ff) dst_dist_ff <= dist_wd;
   end

   assign dst_cur = (dist_we && dist_wa == dst_ff) ? dist_wd : dst_dist_ff;

   always_comb begin
      dist_we = 1'b0;
      dist_wa = ridx_ff;
      dist_wd = relaxed;
      if (init_ph_ff) begin
         dist_we = 1'b1;
         dist_wa = idx_ff;
         dist_wd = (idx_ff == src_ff) ? '0 : DIST_INF;
      end else if (rvalid_ff && relax_ph_ff && !visited_ff[ridx_ff]
                   && row_ff[ridx_ff] && (relaxed < drd_ff)) begin
         dist_we = 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      du_in = du_ff;
      u_in = u_ff;
      pass_in = pass_ff;
      visited_in = visited_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      total_in = total_ff;
      count_in = count_ff;
      if (cmd.clear_step || cmd.scan_step || cmd.relax_step || init_ph_ff)
         idx_in = idx_ff + VB'(1);
      if (cmd.init_search) begin
         idx_in = '0;
         visited_in = '0;
         pass_in = '0;
         best_in = DIST_INF;
         best_idx_in = '0;
         if (!is_all) begin
            src_in = VB'(vtx_a);
            dst_in = VB'(vtx_b);
         end
      end
      if (rvalid_ff && !relax_ph_ff && !visited_ff[ridx_ff]
          && drd_ff <= best_ff) begin
         best_in = drd_ff;
         best_idx_in = ridx_ff;
      end
      // last scanned vertex is still in flight here
      if (cmd.select_done) begin
         u_in = best_idx_in;
         du_in = best_in;
         visited_in[best_idx_in] = 1'b1;
         pass_in = pass_ff + NB'(1);
         idx_in = '0;
      end
      if (cmd.relax_rd) begin
         idx_in = '0;
         best_in = DIST_INF;
         best_idx_in = '0;
      end
      if (cmd.pair_init) begin
         src_in = '0;
         dst_in = VB'(1);
         total_in = '0;
         count_in = '0;
      end
      if (cmd.pair_next) begin
         if (dst_cur != DIST_INF && dst_cur != '0) begin
            total_in = total_ff + TOTAL_BITS'(dst_cur);
            count_in = count_ff + COUNT_BITS'(1);
         end
         if ({1'b0, dst_ff} + NB'(1) >= n_eff) begin
            src_in = src_ff + VB'(1);
            dst_in = src_ff + VB'(2);
         end else begin
            dst_in = dst_ff + VB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         visited_ff <= '0;
         init_ph_ff <= 1'b0;
         relax_ph_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         visited_ff <= visited_in;
         if (cmd.init_search) init_ph_ff <= 1'b1;
         else if (init_ph_ff && {1'b0, idx_ff} + NB'(1) >= n_eff) init_ph_ff <= 1'b0;
         if (cmd.select_done) relax_ph_ff <= 1'b1;
         else if (cmd.relax_rd || cmd.init_search) relax_ph_ff <= 1'b0;
      end
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
      du_ff <= du_in;
      u_ff <= u_in;
      pass_ff <= pass_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      total_ff <= total_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         res_cost <= '0;
         res_found <= 1'b0;
         res_total <= '0;
         res_count <= '0;
         if (is_all) begin
            res_total <= total_ff;
            res_count <= count_ff;
         end else if (query_ok && dst_dist_ff != DIST_INF) begin
            res_cost <= dst_dist_ff;
            res_found <= 1'b1;
         end
      end
   end

   assign sts.clear_last = (32'(idx_ff) == MAX_VERTICES - 1);
   assign sts.present_ab = present_ab_ff && ep_ok;
   assign sts.scan_last = ({1'b0, idx_ff} + NB'(1) >= n_eff);
   assign sts.relax_last = sts.scan_last;
   assign sts.pass_last = (pass_ff + NB'(1) >= n_eff);
   assign sts.best_inf = (du_ff == DIST_INF);
   assign sts.pair_last = ({1'b0, src_ff} + NB'(2) >= n_eff)
                          && ({1'b0, dst_ff} + NB'(1) >= n_eff);
   assign sts.pair_none = (n_eff < NB'(2));

endmodule

// ===== hw/rtl/dgsp_ctrl.sv =====
module dgsp_ctrl
   import dgsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  logic [2:0]   req_kind,
   input  logic         query_ok,
   input  logic         ep_valid,
   input  dgsp_sts_type sts,
   output dgsp_cmd_type cmd,
   output logic         busy,
   output logic         is_all,
   output logic         res_load
);

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_EREAD  = 11'b00000000100,
      ST_EWRITE = 11'b00000001000,
      ST_INIT   = 11'b00000010000,
      ST_SCAN   = 11'b00000100000,
      ST_SDRAIN = 11'b00001000000,
      ST_RELAX  = 11'b00010000000,
      ST_RDRAIN = 11'b00100000000,
      ST_DIST   = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic all_ff, all_in;

   // the accepting cycle already needs the kind of the new request
   assign is_all = req_fire ? (req_kind == REQ_ALL) : all_ff;
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      all_in = all_ff;
      cmd = '0;
      res_load = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in = req_kind;
               all_in = (req_kind == REQ_ALL);
               if (req_kind == REQ_ADD || req_kind == REQ_UPDATE
                   || req_kind == REQ_REMOVE) begin
                  state_in = ep_valid ? ST_EREAD : ST_IDLE;
               end else if (req_kind == REQ_PATH) begin
                  if (query_ok) begin
                     cmd.init_search = 1'b1;
                     state_in = ST_INIT;
                  end else state_in = ST_DONE;
               end else if (req_kind == REQ_ALL) begin
                  cmd.pair_init = 1'b1;
                  state_in = ST_DIST;
               end
            end
         end
         ST_EREAD: begin
            cmd.edge_read = 1'b1;
            state_in = ST_EWRITE;
         end
         ST_EWRITE: begin
            if (kind_ff != REQ_UPDATE || sts.present_ab) begin
               cmd.edge_write_ab = 1'b1;
               cmd.edge_write_ba = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_DIST: begin
            // start search for the current pair
            if (sts.pair_none) state_in = ST_DONE;
            else begin
               cmd.init_search = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (sts.scan_last) begin
               cmd.relax_rd = 1'b1;
               state_in = sts.pass_last ? ST_RDRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_SDRAIN;
         end
         ST_SDRAIN: begin
            cmd.select_done = 1'b1;
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            if (sts.best_inf) begin
               cmd.relax_rd = 1'b1;
               state_in = sts.pass_last ? ST_RDRAIN : ST_SCAN;
            end else begin
               cmd.relax_step = 1'b1;
               if (sts.relax_last) state_in = ST_RDRAIN;
            end
         end
         ST_RDRAIN: begin
            if (!sts.pass_last) begin
               cmd.relax_rd = 1'b1;
               state_in = ST_SCAN;
            end else if (all_ff) begin
               cmd.pair_next = 1'b1;
               state_in = sts.pair_last ? ST_DONE : ST_DIST;
            end else state_in = ST_DONE;
         end
         ST_DONE: begin
            res_load = 1'b1;
            cmd.load_result = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff <= '0;
         all_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         all_ff <= all_in;
      end
   end

endmodule

// ===== hw/rtl/dense_graph_shortest_path.sv =====
// dense_graph_shortest_path: shortest path engine over a dense edge store.
// req_ channel carries one request per transaction: edge add, update and
// remove, a path query, or an all-pairs report. Edge requests give no
// response. Queries and reports give one rsp_ transaction each.
// An edge request with valid endpoints reads the present bit in ST_EREAD and
// writes both directions in ST_EWRITE, unless it updates an absent edge. A
// path query runs the one-vertex-per-cycle init, minimum scan and relaxation
// over the distance memory for N vertices in use; a report repeats it per pair.
// req_tready is low while a request is in progress and while a response
// waits in the output register; a stalled receiver holds the engine.
// After reset the edge-present store is cleared one row per cycle, every row,
// before the first request is taken; vertex_count returns to 50. The user must
// make csr_ writes only while the engine is idle; the block does not enforce it.
// tdata of req_ and rsp_ pack fields from the lowest bit up as listed.
module dense_graph_shortest_path
   import dgsp_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int COST_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // req_type, vertex_a, vertex_b, edge_cost, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // path_cost, path_found, pair_total, pair_count
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [VCNT_BITS-1:0] vcount_ff;
   logic req_fire, busy, is_all, res_load, query_ok;
   logic rsp_valid_ff;
   dgsp_cmd_type cmd;
   dgsp_sts_type sts;
   logic [DIST_BITS-1:0] res_cost;
   logic res_found;
   logic [TOTAL_BITS-1:0] res_total;
   logic [COUNT_BITS-1:0] res_count;
   logic ep_valid;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == {CSR_VERTEX_COUNT, 1'b0})
                       ? 32'(vcount_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= VCNT_RESET;
      else if (csr_psel && csr_penable && csr_pwrite
               && csr_paddr == {CSR_VERTEX_COUNT, 1'b0})
         vcount_ff <= csr_pwdata[VCNT_BITS-1:0];
   end

   assign req_tready = !busy && !rsp_valid_ff;
   assign req_fire = req_tvalid && req_tready;
   assign ep_valid = (32'(req_tdata[8:3]) < MAX_VERTICES)
                     && (32'(req_tdata[14:9]) < MAX_VERTICES);

   // request fields held stable by the engine during work
   logic [2:0] kind_ff;
   logic [5:0] a_ff, b_ff;
   logic [15:0] cost_ff;
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_tdata[2:0];
         a_ff <= req_tdata[8:3];
         b_ff <= req_tdata[14:9];
         cost_ff <= req_tdata[30:15];
      end
   end

   logic [5:0] a_sel, b_sel;
   assign a_sel = req_fire ? req_tdata[8:3] : a_ff;
   assign b_sel = req_fire ? req_tdata[14:9] : b_ff;

   dgsp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .req_kind(req_tdata[2:0]), .query_ok(query_ok), .ep_valid(ep_valid),
      .sts(sts), .cmd(cmd), .busy(busy), .is_all(is_all), .res_load(res_load)
   );

   dgsp_datapath #(.MAX_VERTICES(MAX_VERTICES), .COST_BITS(COST_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_kind(kind_ff), .vtx_a(a_sel), .vtx_b(b_sel), .cost(cost_ff),
      .vcount(vcount_ff), .is_all(is_all), .res_cost(res_cost),
      .res_found(res_found), .res_total(res_total), .res_count(res_count),
      .query_ok(query_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (res_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {res_count, res_total, res_found, res_cost};

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import dgsp_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int NV = 64;

   typedef struct packed {
      logic [23:0] cost;
      logic        found;
      logic [35:0] total;
      logic [10:0] count;
   } path_result_type;

   class scoreboard_type;
      bit          edge_on[NV][NV];
      logic [15:0] edge_w[NV][NV];
      logic [6:0]  vcount;
      path_result_type pending_q[$];
      int          mismatches;
      int          checked;
      int          requests;

      function new();
         vcount = VCNT_RESET;
         mismatches = 0;
         checked = 0;
         requests = 0;
         foreach (edge_on[i, j]) begin
            edge_on[i][j] = 0;
            edge_w[i][j] = '0;
         end
      endfunction

      function int active_n();
         return (vcount < NV) ? int'(vcount) : NV;
      endfunction

      // dijkstra with highest-index tie break and saturation at the sentinel
      function logic [23:0] shortest(int s, int d, int n, output logic found);
         logic [23:0] dist_v[NV];
         bit          seen[NV];
         logic [23:0] best;
         logic [24:0] sum;
         logic [23:0] relaxed;
         int          u;
         found = 0;
         if (s == d || s >= n || d >= n) return '0;
         for (int i = 0; i < n; i++) begin
            dist_v[i] = DIST_INF;
            seen[i] = 0;
         end
         dist_v[s] = '0;
         for (int p = 0; p + 1 < n; p++) begin
            best = DIST_INF;
            u = 0;
            for (int i = 0; i < n; i++)
               if (!seen[i] && dist_v[i] <= best) begin
                  best = dist_v[i];
                  u = i;
               end
            seen[u] = 1;
            if (dist_v[u] == DIST_INF) continue;
            for (int j = 0; j < n; j++)
               if (!seen[j] && edge_on[u][j]) begin
                  sum = {1'b0, dist_v[u]} + {9'd0, edge_w[u][j]};
                  relaxed = (sum >= {1'b0, DIST_INF}) ? DIST_INF : sum[23:0];
                  if (relaxed < dist_v[j]) dist_v[j] = relaxed;
               end
         end
         if (dist_v[d] == DIST_INF) return '0;
         found = 1;
         return dist_v[d];
      endfunction

      function void note_request(logic [31:0] t);
         logic [2:0]   kind;
         int           a, b, n;
         logic [15:0]  w;
         path_result_type r;
         logic         f;
         logic [23:0]  c;
         kind = t[2:0];
         a = t[8:3];
         b = t[14:9];
         w = t[30:15];
         n = active_n();
         requests++;
         r = '0;
         case (kind)
            REQ_ADD, REQ_UPDATE: begin
               if (kind == REQ_ADD || edge_on[a][b]) begin
                  edge_on[a][b] = 1;
                  edge_on[b][a] = 1;
                  edge_w[a][b] = w;
                  edge_w[b][a] = w;
               end
            end
            REQ_REMOVE: begin
               edge_on[a][b] = 0;
               edge_on[b][a] = 0;
            end
            REQ_PATH: begin
               r.cost = shortest(a, b, n, f);
               r.found = f;
               pending_q = {pending_q, r};
            end
            REQ_ALL: begin
               for (int i = 0; i + 1 < n; i++)
                  for (int j = i + 1; j < n; j++) begin
                     c = shortest(i, j, n, f);
                     if (c != 0) begin
                        r.total = r.total + c;
                        r.count = r.count + 1;
                     end
                  end
               pending_q = {pending_q, r};
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [71:0] d);
         path_result_type exp_r, got;
         got.cost = d[23:0];
         got.found = d[24];
         got.total = d[60:25];
         got.count = d[71:61];
         checked++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: cost %h found %b total %h count %0d",
                        got.cost, got.found, got.total, got.count);
            return;
         end
         exp_r = pending_q.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp cost %h found %b total %h count %0d, got cost %h found %b total %h count %0d",
                        exp_r.cost, exp_r.found, exp_r.total, exp_r.count,
                        got.cost, got.found, got.total, got.count);
         end
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // req_type, vertex_a, vertex_b, edge_cost, pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // path_cost, path_found, pair_total, pair_count
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   scoreboard_type sb;
   int send_idle_pct;
   int recv_idle_pct;
   int idle_cycles;
   int settings_used;

   dense_graph_shortest_path i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", sb.pending());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_request(logic [2:0] kind, int a, int b, logic [15:0] w);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, w, b[5:0], a[5:0], kind};
      do @(posedge clock); while (!req_tready);
   endtask

   // wait for all responses and for edge requests to finish
   task automatic drain();
      req_tvalid <= 0;
      do @(posedge clock); while (sb.pending() != 0 || !req_tready);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_vertex_count(logic [6:0] v);
      drain();
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {CSR_VERTEX_COUNT, 1'b0};
      csr_pwdata <= {25'd0, v};
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0;
      csr_penable <= 0;
      sb.vcount = v;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_cost();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'h0000;
      if (r < 20) return 16'hFFFF;
      if (r < 50) return 16'($urandom_range(16'h0300));
      return 16'($urandom);
   endfunction

   function automatic int pick_vertex(int n);
      if ($urandom_range(9) == 0) return $urandom_range(63);
      return $urandom_range((n < NV) ? n : NV - 1);
   endfunction

   task automatic random_phase(int items, int base, int total_items);
      int n, r, done;
      logic [2:0] kind;
      done = 0;
      n = sb.active_n();
      while (done < items) begin
         if (base + done < total_items / 3) begin
            send_idle_pct = 8;
            recv_idle_pct = 47;
         end else if (base + done < 2 * total_items / 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         r = $urandom_range(99);
         if (r < 5) begin
            // unknown request kinds are noise and do not count
            send_request(3'($urandom_range(7, 5)), $urandom_range(63),
                         $urandom_range(63), 16'($urandom));
            continue;
         end
         if (r < 35) kind = REQ_ADD;
         else if (r < 45) kind = REQ_UPDATE;
         else if (r < 55) kind = REQ_REMOVE;
         else if (r < 88 || n > 8) kind = REQ_PATH;
         else kind = REQ_ALL;
         send_request(kind, pick_vertex(n), pick_vertex(n), pick_cost());
         done++;
      end
   endtask

   initial begin
      logic [6:0] phase_vc[8] = '{7'd8, 7'd16, 7'd2, 7'd32, 7'd5, 7'd64, 7'd8, 7'd3};
      sb = new();
      settings_used = 1;
      idle_cycles = 0;
      send_idle_pct = 8;
      recv_idle_pct = 47;
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= '0;
      rsp_tready <= 0;
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed part at the reset vertex count
      send_request(REQ_PATH, 0, 1, 16'h0000);      // nothing reachable yet
      send_request(REQ_ADD, 0, 1, 16'h0100);
      send_request(REQ_ADD, 1, 2, 16'h0200);
      send_request(REQ_ADD, 0, 2, 16'h0300);       // tie with the two-hop route
      send_request(REQ_PATH, 0, 2, 16'h0000);
      send_request(REQ_PATH, 2, 2, 16'h0000);      // same vertex
      send_request(REQ_ADD, 3, 3, 16'h0001);       // self edge
      send_request(REQ_UPDATE, 4, 5, 16'h1234);    // absent edge, no effect
      send_request(REQ_PATH, 4, 5, 16'h0000);
      send_request(REQ_ADD, 4, 5, 16'h0000);       // zero-cost edge
      send_request(REQ_PATH, 5, 4, 16'h0000);
      send_request(REQ_UPDATE, 1, 0, 16'hFFFF);
      send_request(REQ_REMOVE, 2, 1, 16'h0000);
      send_request(REQ_PATH, 1, 2, 16'h0000);
      send_request(REQ_ADD, 63, 62, 16'hFFFF);
      send_request(REQ_PATH, 0, 63, 16'h0000);     // outside the active range
      send_request(3'd7, 63, 63, 16'hFFFF);        // unknown kind
      send_request(REQ_PATH, 49, 0, 16'h0000);
      write_vertex_count(7'd64);
      send_request(REQ_PATH, 62, 63, 16'h0000);
      write_vertex_count(7'd2);
      send_request(REQ_ALL, 0, 0, 16'h0000);
      send_request(REQ_PATH, 1, 0, 16'h0000);
      write_vertex_count(7'd5);
      send_request(REQ_ADD, 3, 4, 16'h0001);
      send_request(REQ_ALL, 0, 0, 16'h0000);

      for (int p = 0; p < 8; p++) begin
         write_vertex_count(phase_vc[p]);
         random_phase(14, 14 * p, 112);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("%0d requests, %0d responses checked, %0d vertex count settings",
               sb.requests, sb.checked, settings_used);
      $display("edge edits, path queries and all-pairs reports under varied backpressure");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
